// ===== design/profile_smooth_threshold_segmenter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the profile segmenter
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PROFILE_SMOOTH_THRESHOLD_SEGMENTER_MACROS_SVH
`define PROFILE_SMOOTH_THRESHOLD_SEGMENTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define PSTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psts: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psts: assertion failed");

`else

`define PSTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/psts_pkg.sv =====
// ----------------------------------------------------------------------------
// psts_pkg
// Shared constants, register codes and types of the profile segmenter.
// ----------------------------------------------------------------------------
package psts_pkg;

	// Sizing of the window store and the datapath.
	localparam int MAX_WINDOW    = 4096;
	localparam int SAMPLE_BITS   = 16;
	localparam int POSITION_BITS = 40;

	localparam int IDX_W  = $clog2(MAX_WINDOW);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + IDX_W;
	localparam int THR_W  = 16;
	localparam int PROD_W = THR_W + WIN_W;
	localparam int WLEN_W = 13;
	localparam int GAP_W  = 40;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic [WLEN_W-1:0] WINDOW_RESET    = WLEN_W'(16);
	localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(4096);

	// Classification queue between front and back (depth is a power of two).
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH   = 2'd0,
		CFG_LEVEL_THRESHOLD = 2'd1,
		CFG_MIN_GAP_LENGTH  = 2'd2
	} psts_cfg_reg_t;

	// Register values as seen by the datapath.
	typedef struct packed {
		logic [WIN_W-1:0] win;
		logic [THR_W-1:0] thr;
		logic [GAP_W-1:0] gap;
	} psts_cfg_t;

	// One classified position as it waits in the queue.
	typedef struct packed {
		logic high;
		logic last;
	} psts_class_t;

	// A zero window behaves as one, a window above the store behaves as the store.
	function automatic logic [WIN_W-1:0] clamp_window(input logic [WLEN_W-1:0] len);
		logic [WIN_W-1:0] res;
		if (len == '0) begin
			res = WIN_W'(1);
		end else if (len > WLEN_W'(MAX_WINDOW)) begin
			res = WIN_W'(MAX_WINDOW);
		end else begin
			res = WIN_W'(len);
		end
		return res;
	endfunction

endpackage

// ===== design/psts_in_if.sv =====
// ----------------------------------------------------------------------------
// psts_in_if
// Sample channel: forward and reverse values of one position.
// ----------------------------------------------------------------------------
interface psts_in_if;
	logic                             valid;
	logic                             ready;
	logic [psts_pkg::SAMPLE_BITS-1:0] forward_bits;
	logic [psts_pkg::SAMPLE_BITS-1:0] reverse_bits;
	logic                             last_sample;

	modport source (output valid, output forward_bits, output reverse_bits,
		output last_sample, input ready);
	modport sink (input valid, input forward_bits, input reverse_bits,
		input last_sample, output ready);
endinterface

// ===== design/psts_out_if.sv =====
// ----------------------------------------------------------------------------
// psts_out_if
// Region channel: start and end position of one reported low region.
// ----------------------------------------------------------------------------
interface psts_out_if;
	logic                               valid;
	logic                               ready;
	logic [psts_pkg::POSITION_BITS-1:0] low_start;
	logic [psts_pkg::POSITION_BITS-1:0] low_end;

	modport source (output valid, output low_start, output low_end, input ready);
	modport sink (input valid, input low_start, input low_end, output ready);
endinterface

// ===== design/psts_cfg_if.sv =====
// ----------------------------------------------------------------------------
// psts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface psts_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psts_pkg::CFG_IDX_W-1:0]  index;
	logic [psts_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/psts_front.sv =====
// ----------------------------------------------------------------------------
// psts_front
// Takes samples, keeps the moving-window sum over the ring store and marks
// each position high or low against the scaled threshold.
// ----------------------------------------------------------------------------
`include "profile_smooth_threshold_segmenter_macros.svh"

module psts_front (
	input  logic                           clk,
	input  logic                           arst_n,
	psts_in_if.sink                        samples,
	input  psts_pkg::psts_cfg_t            cfg_regs,
	input  logic [psts_pkg::QCNT_W-1:0]    queue_count,
	output logic                           push,
	output psts_pkg::psts_class_t          push_item
);

	logic [psts_pkg::SAMPLE_BITS-1:0] store [psts_pkg::MAX_WINDOW];

	logic                             clr_busy_q;
	logic [psts_pkg::IDX_W-1:0]       clr_addr_q;
	logic [psts_pkg::IDX_W-1:0]       ring_q;
	logic [psts_pkg::SUM_W-1:0]       sum_q;
	logic [psts_pkg::PROD_W-1:0]      thr_win_q;

	logic                             valid_s1;
	logic [psts_pkg::IDX_W-1:0]       slot_s1;
	logic [psts_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic                             last_s1;
	logic [psts_pkg::SAMPLE_BITS-1:0] rdata_s1;
	logic                             bypass_s1;
	logic [psts_pkg::SAMPLE_BITS-1:0] bypass_data_s1;

	logic                             accept;
	logic [psts_pkg::SAMPLE_BITS-1:0] min_val;
	logic [psts_pkg::IDX_W-1:0]       slot;
	logic [psts_pkg::WIN_W-1:0]       slot_inc;
	logic [psts_pkg::IDX_W-1:0]       ring_next;
	logic                             mem_we;
	logic [psts_pkg::IDX_W-1:0]       mem_waddr;
	logic [psts_pkg::SAMPLE_BITS-1:0] mem_wdata;
	logic [psts_pkg::SAMPLE_BITS-1:0] old_val;
	logic [psts_pkg::SUM_W-1:0]       sum_new;
	logic [psts_pkg::QCNT_W:0]        in_flight;

	// Space check: the queue must hold everything already in flight plus this item.
	assign in_flight = {1'b0, queue_count} + (psts_pkg::QCNT_W + 1)'(valid_s1);
	assign samples.ready = !clr_busy_q &&
		(in_flight < (psts_pkg::QCNT_W + 1)'(psts_pkg::QUEUE_DEPTH));
	assign accept = samples.valid && samples.ready;

	// Minimum of both directions and the ring slot it lands in.
	always_comb begin
		min_val  = (samples.reverse_bits < samples.forward_bits) ?
			samples.reverse_bits : samples.forward_bits;
		slot     = ({1'b0, ring_q} < cfg_regs.win) ? ring_q : '0;
		slot_inc = psts_pkg::WIN_W'({1'b0, slot}) + psts_pkg::WIN_W'(1);
		ring_next = (slot_inc >= cfg_regs.win) ? '0 : slot_inc[psts_pkg::IDX_W-1:0];
	end

	// Clearing pass after reset, then the ring pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			ring_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + psts_pkg::IDX_W'(1);
				if (clr_addr_q == psts_pkg::IDX_W'(psts_pkg::MAX_WINDOW - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				ring_q <= ring_next;
			end
			valid_s1 <= accept;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1   <= slot;
			sample_s1 <= min_val;
			last_s1   <= samples.last_sample;
		end
		bypass_s1      <= valid_s1 && (slot_s1 == slot);
		bypass_data_s1 <= sample_s1;
		thr_win_q      <= psts_pkg::PROD_W'(cfg_regs.thr) * psts_pkg::PROD_W'(cfg_regs.win);
	end

	// Write port: zeros during the clearing pass, otherwise the new sample.
	always_comb begin
		mem_we    = clr_busy_q || valid_s1;
		mem_waddr = clr_busy_q ? clr_addr_q : slot_s1;
		mem_wdata = clr_busy_q ? '0 : sample_s1;
	end

	// Window store with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= store[slot];
	end

	// Sum update and classification.
	always_comb begin
		old_val = bypass_s1 ? bypass_data_s1 : rdata_s1;
		sum_new = sum_q - psts_pkg::SUM_W'(old_val) + psts_pkg::SUM_W'(sample_s1);
		push    = valid_s1;
		push_item.high = (psts_pkg::PROD_W'(sum_new) >= thr_win_q);
		push_item.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s1) begin
			sum_q <= sum_new;
		end
	end

	`PSTS_ASSERT_IMP(a_no_take_while_clearing, clk, arst_n, clr_busy_q, !samples.ready)
	`PSTS_ASSERT_NEXT(a_take_reaches_s1, clk, arst_n, accept, valid_s1)

endmodule

// ===== design/psts_queue.sv =====
// ----------------------------------------------------------------------------
// psts_queue
// Short queue of classified positions between front and back.
// ----------------------------------------------------------------------------
`include "profile_smooth_threshold_segmenter_macros.svh"

module psts_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  psts_pkg::psts_class_t       push_item,
	input  logic                        pop,
	output psts_pkg::psts_class_t       head,
	output logic                        not_empty,
	output logic [psts_pkg::QCNT_W-1:0] count
);

	psts_pkg::psts_class_t        entry_q [psts_pkg::QUEUE_DEPTH];
	logic [psts_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [psts_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [psts_pkg::QCNT_W-1:0]  count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + psts_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + psts_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + psts_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - psts_pkg::QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`PSTS_ASSERT_IMP(a_no_overflow, clk, arst_n, push,
		count_q < psts_pkg::QCNT_W'(psts_pkg::QUEUE_DEPTH) || pop)

endmodule

// ===== design/psts_back.sv =====
// ----------------------------------------------------------------------------
// psts_back
// Follows low and high regions over positions and reports low regions that
// are long enough.
// ----------------------------------------------------------------------------
`include "profile_smooth_threshold_segmenter_macros.svh"

module psts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [psts_pkg::GAP_W-1:0]    gap,
	input  psts_pkg::psts_class_t         head,
	input  logic                          not_empty,
	output logic                          pop,
	psts_out_if.source                    regions
);

	logic [psts_pkg::POSITION_BITS-1:0] pos_q;
	logic [psts_pkg::POSITION_BITS-1:0] begin_q;
	logic                               in_high_q;
	logic                               out_valid_q;
	logic [psts_pkg::POSITION_BITS-1:0] low_start_q;
	logic [psts_pkg::POSITION_BITS-1:0] low_end_q;

	logic                               first_pos;
	logic [psts_pkg::POSITION_BITS-1:0] region_len;
	logic                               report;

	// Take a position when the output register is free or being emptied.
	assign pop = not_empty && (!out_valid_q || regions.ready);

	// A low region closes on a rise to high or at the end of the stream.
	always_comb begin
		first_pos  = (pos_q == psts_pkg::POSITION_BITS'(1));
		region_len = pos_q - begin_q;
		report     = !first_pos && !in_high_q && (head.high || head.last) &&
			(psts_pkg::GAP_W'(region_len) > gap);
	end

	// Region state and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= psts_pkg::POSITION_BITS'(1);
			begin_q     <= psts_pkg::POSITION_BITS'(1);
			in_high_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q <= pos_q + psts_pkg::POSITION_BITS'(1);
				if (first_pos) begin
					in_high_q <= head.high;
					begin_q   <= psts_pkg::POSITION_BITS'(1);
				end else if (head.high && !in_high_q) begin
					in_high_q <= 1'b1;
				end else if (!head.high && in_high_q) begin
					in_high_q <= 1'b0;
					begin_q   <= pos_q;
				end
				out_valid_q <= report;
			end else if (regions.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (pop && report) begin
			low_start_q <= begin_q;
			low_end_q   <= pos_q;
		end
	end

	assign regions.valid     = out_valid_q;
	assign regions.low_start = low_start_q;
	assign regions.low_end   = low_end_q;

	`PSTS_ASSERT_IMP(a_stall_blocks_pop, clk, arst_n, out_valid_q && !regions.ready, !pop)

endmodule

// ===== design/profile_smooth_threshold_segmenter.sv =====
// ----------------------------------------------------------------------------
// profile_smooth_threshold_segmenter
// Moving-average threshold segmentation of an information profile.
// ----------------------------------------------------------------------------
// Usage:
// The samples channel carries one stream position per item: forward and
// reverse values in unsigned Q4.12 and a last-position flag. The regions
// channel carries one item per reported low region (1-based start and end).
// The cfg channel writes window_length (0), level_threshold (1) and
// min_gap_length (2); it is always ready, and the user must write it only while
// the block idles, which the block does not enforce. Throughput is one sample
// per cycle while regions are taken and no clearing pass runs, set by one read
// and one write of the window store per cycle, with a bypass when a slot is
// reused at once. A result passes the stage-one and store-read registers, the
// queue and the result register before it is valid on regions. After reset the
// block runs a clearing pass over the 4096-entry window store, taking no samples
// until it ends; register writes are taken during it. A stalled regions receiver
// holds the result register; the four-entry queue behind it keeps taking samples
// until it fills, then samples.ready drops. A new stream starts with a reset.
// ----------------------------------------------------------------------------
module profile_smooth_threshold_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	psts_in_if.sink     samples,
	psts_out_if.source  regions,
	psts_cfg_if.sink    cfg
);

	logic [psts_pkg::WIN_W-1:0] window_q;
	logic [psts_pkg::THR_W-1:0] threshold_q;
	logic [psts_pkg::GAP_W-1:0] gap_q;

	psts_pkg::psts_cfg_t   cfg_regs;
	logic                  push;
	psts_pkg::psts_class_t push_item;
	logic                  pop;
	psts_pkg::psts_class_t head;
	logic                  not_empty;
	logic [psts_pkg::QCNT_W-1:0] queue_count;

	assign cfg.ready = 1'b1;

	// Configuration registers; the window is stored already clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= psts_pkg::clamp_window(psts_pkg::WINDOW_RESET);
			threshold_q <= psts_pkg::THRESHOLD_RESET;
			gap_q       <= '0;
		end else if (cfg.valid) begin
			case (psts_pkg::psts_cfg_reg_t'(cfg.index))
				psts_pkg::CFG_WINDOW_LENGTH: begin
					window_q <= psts_pkg::clamp_window(cfg.data[psts_pkg::WLEN_W-1:0]);
				end
				psts_pkg::CFG_LEVEL_THRESHOLD: begin
					threshold_q <= cfg.data[psts_pkg::THR_W-1:0];
				end
				psts_pkg::CFG_MIN_GAP_LENGTH: begin
					gap_q <= cfg.data[psts_pkg::GAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_regs.win = window_q;
	assign cfg_regs.thr = threshold_q;
	assign cfg_regs.gap = gap_q;

	psts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.cfg_regs    (cfg_regs),
		.queue_count (queue_count),
		.push        (push),
		.push_item   (push_item)
	);

	psts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (queue_count)
	);

	psts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gap       (cfg_regs.gap),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.regions   (regions)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the profile segmenter. A short table of directed
// rows comes first, then random runs of low and high samples under several
// register settings and handshake paces. Each reported region is checked against
// a behavioral predictor of the moving-window threshold logic, or a typed-in region.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import psts_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 80;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} pace_t;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_CONFIG
	} row_kind_t;

	// How a sample row is checked: by the predictor, by a typed-in result, or not at all.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_REGION
	} check_t;

	typedef struct packed {
		logic [POSITION_BITS-1:0] start_pos;
		logic [POSITION_BITS-1:0] end_pos;
	} region_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [SAMPLE_BITS-1:0]   fwd;
		logic [SAMPLE_BITS-1:0]   rev;
		logic                     fin;
		psts_cfg_reg_t            sel;
		logic [CFG_DATA_W-1:0]    data;
		check_t                   chk;
		logic [POSITION_BITS-1:0] exp_start;
		logic [POSITION_BITS-1:0] exp_end;
	} script_row_t;

	typedef struct packed {
		logic [WLEN_W-1:0] win;
		logic [THR_W-1:0]  thr;
		logic [GAP_W-1:0]  gap;
		pace_t             pace;
		logic [15:0]       count;
		logic              squeeze;
	} phase_t;

	// Directed rows, starting from the reset settings (window 16, threshold 1.0).
	localparam script_row_t SCRIPT [21] = '{
		'{ROW_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_NONE, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_NONE, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_REGION, 40'd1, 40'd3},
		'{ROW_SAMPLE, 16'h0000, 16'hFFFF, 1'b1, CFG_WINDOW_LENGTH, 40'd0, CHK_NONE, 40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_WINDOW_LENGTH, 40'd1, CHK_NONE, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h1234, 16'hABCD, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_LEVEL_THRESHOLD, 40'hFFFF, CHK_NONE,
			40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_WINDOW_LENGTH, 40'd8191, CHK_NONE,
			40'd0, 40'd0},
		'{ROW_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h0000, 16'h8000, 1'b1, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_MIN_GAP_LENGTH, 40'hFF_FFFF_FFFF, CHK_NONE,
			40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h7FFF, 16'h8000, 1'b1, CFG_WINDOW_LENGTH, 40'd0, CHK_NONE, 40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_LEVEL_THRESHOLD, 40'd0, CHK_NONE,
			40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_NONE, 40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_MIN_GAP_LENGTH, 40'd0, CHK_NONE,
			40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_NONE, 40'd0, 40'd0},
		'{ROW_CONFIG, 16'h0000, 16'h0000, 1'b0, CFG_LEVEL_THRESHOLD, 40'h9000, CHK_NONE,
			40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h5000, 16'hF000, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0},
		'{ROW_SAMPLE, 16'h0001, 16'h0000, 1'b1, CFG_WINDOW_LENGTH, 40'd0, CHK_MODEL, 40'd0, 40'd0}
	};

	// Random phases. Windows only shrink after a flush of zero samples, so no
	// stale store entry outside the window skews the average.
	localparam phase_t PHASES [9] = '{
		'{13'd16,   16'h1000, 40'd0, IDLE_NONE, 16'd130, 1'b0},
		'{13'd4,    16'h8000, 40'd1, IDLE_SEND, 16'd130, 1'b0},
		'{13'd1,    16'hFFFF, 40'd0, IDLE_RECV, 16'd120, 1'b0},
		'{13'd0,    16'h2000, 40'd0, IDLE_NONE, 16'd110, 1'b1},
		'{13'd8,    16'h0001, 40'd3, IDLE_BOTH, 16'd130, 1'b0},
		'{13'd12,   16'hC000, 40'd0, IDLE_SEND, 16'd130, 1'b0},
		'{13'd3,    16'h4000, 40'd2, IDLE_RECV, 16'd130, 1'b0},
		'{13'd32,   16'h6000, 40'd0, IDLE_BOTH, 16'd130, 1'b0},
		'{13'd8191, 16'h0040, 40'd0, IDLE_NONE, 16'd60,  1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	psts_in_if  sample_ch ();
	psts_out_if region_ch ();
	psts_cfg_if reg_ch ();

	profile_smooth_threshold_segmenter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.regions (region_ch),
		.cfg     (reg_ch)
	);

	// Predictor state and its copy of the registers.
	logic [SAMPLE_BITS-1:0]   ring_mem [MAX_WINDOW];
	longint unsigned          acc = 0;
	int unsigned              ring_pos = 0;
	logic [POSITION_BITS-1:0] posn = '0;
	logic                     in_high = 1'b0;
	logic [POSITION_BITS-1:0] zone_begin = POSITION_BITS'(1);
	logic [WLEN_W-1:0]        win_len = WINDOW_RESET;
	logic [THR_W-1:0]         thr_level = THRESHOLD_RESET;
	logic [GAP_W-1:0]         gap_len = '0;

	region_t pending_regions [$];
	int      fault_count = 0;
	pace_t   pace = IDLE_NONE;
	logic    squeeze_on = 1'b0;
	logic    squeeze_done = 1'b0;

	initial begin
		foreach (ring_mem[i]) ring_mem[i] = '0;
	end

	// Clock and reset.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Time limit for the whole run.
	initial begin
		#400us;
		$display("tb_top failed");
		$finish;
	end

	function automatic int unsigned span_of(input logic [WLEN_W-1:0] len);
		if (len == '0) begin
			return 1;
		end else if (len > WLEN_W'(MAX_WINDOW)) begin
			return MAX_WINDOW;
		end
		return int'(len);
	endfunction

	// A low region ending at the current position is reported if long enough.
	function automatic logic close_zone(output region_t found);
		logic [POSITION_BITS-1:0] span;
		span = posn - zone_begin;
		found.start_pos = zone_begin;
		found.end_pos = posn;
		return span > gap_len;
	endfunction

	// Advance the predictor by one sample; returns 1 when a region is reported.
	function automatic logic advance_profile(input logic [SAMPLE_BITS-1:0] fwd,
		input logic [SAMPLE_BITS-1:0] rev, input logic fin, output region_t found);
		logic [SAMPLE_BITS-1:0] v;
		int unsigned            w;
		int unsigned            slot;
		logic                   up;
		logic                   hit;
		hit = 1'b0;
		found = '0;
		v = (rev < fwd) ? rev : fwd;
		w = span_of(win_len);
		slot = (ring_pos < w) ? ring_pos : 0;
		acc = acc - ring_mem[slot] + v;
		ring_mem[slot] = v;
		slot++;
		ring_pos = (slot >= w) ? 0 : slot;
		posn = posn + 1'b1;
		up = acc >= 64'(thr_level) * 64'(w);

		if (posn == POSITION_BITS'(1)) begin
			in_high = up;
			zone_begin = POSITION_BITS'(1);
		end else if (up) begin
			if (!in_high) begin
				in_high = 1'b1;
				hit = close_zone(found);
			end
		end else if (in_high) begin
			in_high = 1'b0;
			zone_begin = posn;
		end

		if (fin && !in_high) begin
			hit = close_zone(found);
		end
		return hit;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Offer one sample item, with random idle cycles ahead of it, and record
	// what the block must report for it once it is taken.
	task automatic offer_sample(input logic [SAMPLE_BITS-1:0] fwd,
		input logic [SAMPLE_BITS-1:0] rev, input logic fin, input check_t chk,
		input region_t typed);
		int unsigned idle_pct;
		region_t     found;
		logic        hit;
		idle_pct = (pace == IDLE_SEND) ? 47 : (pace == IDLE_BOTH) ? 21 : 0;
		while ($urandom_range(99, 0) < idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.forward_bits <= fwd;
		sample_ch.reverse_bits <= rev;
		sample_ch.last_sample <= fin;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);

		hit = advance_profile(fwd, rev, fin, found);
		case (chk)
			CHK_MODEL: begin
				if (hit) pending_regions.push_back(found);
			end
			CHK_REGION: begin
				pending_regions.push_back(typed);
			end
			default: begin
			end
		endcase
	endtask

	// The given minimum goes on a random side, the other side lies at or above it.
	task automatic offer_min(input logic [SAMPLE_BITS-1:0] v, input logic fin);
		logic [SAMPLE_BITS-1:0] other;
		other = SAMPLE_BITS'($urandom_range(65535, v));
		if ($urandom_range(1, 0) == 1) begin
			offer_sample(v, other, fin, CHK_MODEL, '0);
		end else begin
			offer_sample(other, v, fin, CHK_MODEL, '0);
		end
	endtask

	// Write one register; valid stays high for a following write.
	task automatic reg_write(input psts_cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= sel;
		reg_ch.data <= data;
		@(posedge clk);
		while (!reg_ch.ready) @(posedge clk);
		case (sel)
			CFG_WINDOW_LENGTH:   win_len = data[WLEN_W-1:0];
			CFG_LEVEL_THRESHOLD: thr_level = data[THR_W-1:0];
			CFG_MIN_GAP_LENGTH:  gap_len = data[GAP_W-1:0];
			default: begin
			end
		endcase
	endtask

	// Stop offering, wait for every expected region, then let the pipeline empty.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_regions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Region receiver: random stalls by pace, and one long hold-off.
	initial begin : region_receiver
		int unsigned stall_pct;
		int unsigned hold_cnt;
		region_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall_pct = (pace == IDLE_RECV) ? 47 : (pace == IDLE_BOTH) ? 21 : 0;
			if (squeeze_on && !squeeze_done) begin
				squeeze_done = 1'b1;
				region_ch.ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
			end
			region_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// Region checker: each taken item against the oldest expectation.
	always @(posedge clk) begin : region_checker
		region_t want;
		if (arst_n && region_ch.valid && region_ch.ready) begin
			if (pending_regions.size() == 0) begin
				note_fault($sformatf("unexpected region %0d..%0d",
					region_ch.low_start, region_ch.low_end));
			end else begin
				want = pending_regions.pop_front();
				if (region_ch.low_start !== want.start_pos) begin
					note_fault($sformatf("low_start mismatch: expected %0d, got %0d",
						want.start_pos, region_ch.low_start));
				end
				if (region_ch.low_end !== want.end_pos) begin
					note_fault($sformatf("low_end mismatch: expected %0d, got %0d",
						want.end_pos, region_ch.low_end));
				end
			end
		end
	end

	// Stimulus: directed rows, then random phases.
	initial begin : stimulus
		script_row_t row;
		phase_t      ph;
		logic        dirty;
		int unsigned effw;
		int unsigned done;
		int unsigned len;
		int unsigned k;
		logic        hi;
		logic [SAMPLE_BITS-1:0] v;

		sample_ch.valid <= 1'b0;
		sample_ch.forward_bits <= '0;
		sample_ch.reverse_bits <= '0;
		sample_ch.last_sample <= 1'b0;
		reg_ch.valid <= 1'b0;
		reg_ch.index <= CFG_WINDOW_LENGTH;
		reg_ch.data <= '0;
		dirty = 1'b0;

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		for (int i = 0; i < $size(SCRIPT); i++) begin
			row = SCRIPT[i];
			if (row.kind == ROW_CONFIG) begin
				if (dirty) begin
					settle();
					dirty = 1'b0;
				end
				reg_write(row.sel, row.data);
				if (i + 1 == $size(SCRIPT) || SCRIPT[i + 1].kind != ROW_CONFIG) begin
					reg_ch.valid <= 1'b0;
				end
			end else begin
				offer_sample(row.fwd, row.rev, row.fin, row.chk,
					'{row.exp_start, row.exp_end});
				dirty = 1'b1;
			end
		end

		foreach (PHASES[p]) begin
			ph = PHASES[p];
			settle();
			reg_write(CFG_WINDOW_LENGTH, CFG_DATA_W'(ph.win));
			reg_write(CFG_LEVEL_THRESHOLD, CFG_DATA_W'(ph.thr));
			reg_write(CFG_MIN_GAP_LENGTH, CFG_DATA_W'(ph.gap));
			reg_ch.valid <= 1'b0;
			pace = ph.pace;
			squeeze_on = ph.squeeze;
			effw = span_of(ph.win);

			// Runs of high or low samples; one in four is at most a window long, the rest at least a window long.
			done = 0;
			while (done < ph.count) begin
				hi = 1'($urandom_range(1, 0));
				if ($urandom_range(3, 0) == 0) begin
					len = $urandom_range(effw, 1);
				end else begin
					len = $urandom_range(3 * effw, effw);
				end
				if (len > ph.count - done) len = ph.count - done;
				for (k = 0; k < len; k++) begin
					if (hi) begin
						v = SAMPLE_BITS'($urandom_range(65535, ph.thr));
					end else if (ph.thr == '0) begin
						v = '0;
					end else begin
						v = SAMPLE_BITS'($urandom_range(ph.thr - 1, 0));
					end
					offer_min(v, $urandom_range(99, 0) < 3);
				end
				done += len;
			end

			// Zero flush ends the stream segment low and clears the window.
			if (p != $size(PHASES) - 1) begin
				for (k = 0; k < effw; k++) begin
					offer_min('0, k == effw - 1);
				end
			end
			squeeze_on = 1'b0;
		end

		settle();
		if (fault_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
